/* rtl/core/goc_pkg.sv */
package goc_pkg;

  localparam int unsigned AngleTableLen = 24;
  localparam int unsigned CordicScaleShift = 14;
  localparam int unsigned VecW = 33;
  localparam int unsigned ZW = 26;
  localparam int unsigned AtanW = 22;
  localparam int unsigned DegW = 11;

  localparam logic [15:0] MinIntervalReset = 16'd200;
  localparam logic [3:0] TiltRatioReset = 4'd3;

  localparam int HalfTurnDeg = 180;
  localparam int QuarterTurnDeg = 90;
  localparam int FullTurnDeg = 360;
  localparam int Rot0Hi = 30;
  localparam int Rot0Lo = 330;
  localparam int Rot90Lo = 60;
  localparam int Rot90Hi = 120;
  localparam int Rot180Lo = 150;
  localparam int Rot180Hi = 210;
  localparam int Rot270Lo = 240;
  localparam int Rot270Hi = 300;
  localparam logic signed [ZW-1:0] HalfTurnQ16 = ZW'(HalfTurnDeg * 65536);
  localparam logic [ZW-1:0] RoundHalfQ16 = ZW'(32768);

  localparam logic [AtanW-1:0] AtanQ16 [AngleTableLen] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
    22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
    22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0
  };

  typedef enum logic [2:0] {
    ORIENT_ROT0    = 3'd0,
    ORIENT_ROT90   = 3'd1,
    ORIENT_ROT180  = 3'd2,
    ORIENT_ROT270  = 3'd3,
    ORIENT_INVALID = 3'd4
  } orient_e;

  typedef enum logic [1:0] {
    BASE_NONE = 2'd0,
    BASE_POS  = 2'd1,
    BASE_NEG  = 2'd2
  } base_e;

  typedef enum logic {
    REG_MIN_INTERVAL = 1'b0,
    REG_TILT_RATIO   = 1'b1
  } reg_e;

  typedef struct packed {
    logic                  vld;
    logic signed [VecW-1:0] a;
    logic signed [VecW-1:0] b;
    logic signed [ZW-1:0]   z;
  } vec_t;

endpackage

/* rtl/core/goc_cordic_cell.sv */
module goc_cordic_cell
  import goc_pkg::*;
#(
  parameter int unsigned Step = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  vec_t vec_i,
  output vec_t vec_o
);

  vec_t vec_d, vec_q;
  logic signed [VecW-1:0] da, db;
  logic signed [ZW-1:0] dz;

  always_comb begin
    da = vec_i.b >>> Step;
    db = vec_i.a >>> Step;
    dz = $signed({{(ZW - AtanW){1'b0}}, AtanQ16[Step]});
    vec_d.vld = vec_i.vld;
    if (!vec_i.b[VecW-1]) begin
      vec_d.a = vec_i.a + da;
      vec_d.b = vec_i.b - db;
      vec_d.z = vec_i.z + dz;
    end else begin
      vec_d.a = vec_i.a - da;
      vec_d.b = vec_i.b + db;
      vec_d.z = vec_i.z - dz;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vec_q <= '0;
    end else begin
      vec_q <= vec_d;
    end
  end

  assign vec_o = vec_q;

endmodule

/* rtl/core/goc_tilt.sv */
module goc_tilt
  import goc_pkg::*;
(
  input  logic               clk_i,
  input  logic signed [15:0] x_i,
  input  logic signed [15:0] y_i,
  input  logic signed [15:0] z_i,
  input  logic        [3:0]  ratio_i,
  output logic               flat_o
);

  logic signed [31:0] xx_d, yy_d, zz_d;
  logic [30:0] xx_q, yy_q, zz_q;
  logic [31:0] horiz;
  logic [35:0] scaled;
  logic flat_q;

  always_comb begin
    xx_d = x_i * x_i;
    yy_d = y_i * y_i;
    zz_d = z_i * z_i;
    horiz = {1'b0, xx_q} + {1'b0, yy_q};
    scaled = {4'b0, horiz} * {32'b0, ratio_i};
  end

  always_ff @(posedge clk_i) begin
    xx_q <= xx_d[30:0];
    yy_q <= yy_d[30:0];
    zz_q <= zz_d[30:0];
    flat_q <= scaled < {5'b0, zz_q};
  end

  assign flat_o = flat_q;

endmodule

/* rtl/core/gravity_orientation_classifier_top.sv */
// An accepted gravity word passes the entry register, the CORDIC cell row and the pending
// register to the output register; no new word is taken until it has left the pending register.
// Dropped or non-gravity words are accepted without starting the cell row and give no output word.
// A finished word waits in the output register while the next word is taken.
// Reset: rst_ni is asynchronous, active low; min interval 200, tilt ratio 3, last time 0.
module gravity_orientation_classifier_top
  import goc_pkg::*;
#(
  parameter int unsigned ANGLE_ITERATIONS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic        [2:0]  paddr,
  input  logic        [31:0] pwdata,
  output logic        [31:0] prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] gravity_x_i,
  input  logic signed [15:0] gravity_y_i,
  input  logic signed [15:0] gravity_z_i,
  input  logic        [31:0] time_ms_i,
  input  logic               is_gravity_type_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic        [2:0]  orientation_o,
  output logic signed [9:0]  angle_deg_o,
  output logic               is_flat_o
);

  logic [15:0] min_q;
  logic [3:0] ratio_q;
  logic [31:0] last_q;
  logic busy_q, pend_q, out_valid_q;
  logic signed [15:0] x_q, y_q, z_q;
  base_e base_q, base_d;
  logic zero_q, zero_d;
  vec_t vec [ANGLE_ITERATIONS+1];
  vec_t entry_d, entry_q;
  logic flat;
  logic in_acc, pass, take, cfg_wr, move;
  logic [31:0] diff;
  logic signed [16:0] a0, b0;
  logic signed [ZW-1:0] z_tot;
  logic [ZW-1:0] mag, rnd;
  logic signed [DegW-1:0] angle, deg_raw, deg;
  orient_e orient_d;
  orient_e pend_orient_q, out_orient_q;
  logic signed [9:0] pend_angle_q, out_angle_q;
  logic pend_flat_q, out_flat_q;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (reg_e'(paddr[2]) == REG_TILT_RATIO) ? {28'b0, ratio_q} : {16'b0, min_q};

  assign in_ready_o = !busy_q;
  assign in_acc = in_valid_i && in_ready_o;
  assign diff = time_ms_i - last_q;
  assign pass = diff >= {16'b0, min_q};
  assign take = in_acc && pass && is_gravity_type_i;
  assign move = pend_q && (!out_valid_q || out_ready_i);

  always_comb begin
    a0 = -{gravity_x_i[15], gravity_x_i};
    b0 = {gravity_y_i[15], gravity_y_i};
    base_d = BASE_NONE;
    if (a0[16]) begin
      a0 = -a0;
      b0 = -b0;
      base_d = gravity_y_i[15] ? BASE_NEG : BASE_POS;
    end
    zero_d = (gravity_x_i == 16'sd0) && (gravity_y_i == 16'sd0);
    entry_d.vld = take;
    entry_d.a = $signed({{(VecW - 17 - CordicScaleShift){a0[16]}}, a0,
                         {CordicScaleShift{1'b0}}});
    entry_d.b = $signed({{(VecW - 17 - CordicScaleShift){b0[16]}}, b0,
                         {CordicScaleShift{1'b0}}});
    entry_d.z = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= MinIntervalReset;
      ratio_q <= TiltRatioReset;
      last_q <= '0;
      busy_q <= 1'b0;
      pend_q <= 1'b0;
      out_valid_q <= 1'b0;
      entry_q <= '0;
    end else begin
      if (cfg_wr) begin
        case (reg_e'(paddr[2]))
          REG_MIN_INTERVAL: min_q <= pwdata[15:0];
          REG_TILT_RATIO:   ratio_q <= pwdata[3:0];
          default: ;
        endcase
      end
      if (in_acc && pass) begin
        last_q <= time_ms_i;
      end
      entry_q <= entry_d;
      if (take) begin
        busy_q <= 1'b1;
      end else if (move) begin
        busy_q <= 1'b0;
      end
      if (vec[ANGLE_ITERATIONS].vld) begin
        pend_q <= 1'b1;
      end else if (move) begin
        pend_q <= 1'b0;
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      x_q <= gravity_x_i;
      y_q <= gravity_y_i;
      z_q <= gravity_z_i;
      base_q <= base_d;
      zero_q <= zero_d;
    end
  end

  goc_tilt u_tilt (
    .clk_i   (clk_i),
    .x_i     (x_q),
    .y_i     (y_q),
    .z_i     (z_q),
    .ratio_i (ratio_q),
    .flat_o  (flat)
  );

  assign vec[0] = entry_q;

  for (genvar i = 0; i < ANGLE_ITERATIONS; i++) begin : g_cell
    goc_cordic_cell #(
      .Step (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vec_i  (vec[i]),
      .vec_o  (vec[i+1])
    );
  end

  always_comb begin
    z_tot = vec[ANGLE_ITERATIONS].z;
    case (base_q)
      BASE_POS: z_tot = vec[ANGLE_ITERATIONS].z + HalfTurnQ16;
      BASE_NEG: z_tot = vec[ANGLE_ITERATIONS].z - HalfTurnQ16;
      default:  z_tot = vec[ANGLE_ITERATIONS].z;
    endcase
    mag = z_tot[ZW-1] ? ZW'(-z_tot) : ZW'(z_tot);
    rnd = (mag + RoundHalfQ16) >> 16;
    angle = z_tot[ZW-1] ? -$signed(rnd[DegW-1:0]) : $signed(rnd[DegW-1:0]);
    if (zero_q) begin
      angle = DegW'(HalfTurnDeg);
    end
    deg_raw = DegW'(QuarterTurnDeg) - angle;
    deg = deg_raw;
    if (deg_raw < 0) begin
      deg = deg_raw + DegW'(FullTurnDeg);
    end else if (deg_raw >= DegW'(FullTurnDeg)) begin
      deg = deg_raw - DegW'(FullTurnDeg);
    end
    if (deg <= DegW'(Rot0Hi) || deg >= DegW'(Rot0Lo)) begin
      orient_d = ORIENT_ROT0;
    end else if (deg >= DegW'(Rot90Lo) && deg <= DegW'(Rot90Hi)) begin
      orient_d = ORIENT_ROT90;
    end else if (deg >= DegW'(Rot180Lo) && deg <= DegW'(Rot180Hi)) begin
      orient_d = ORIENT_ROT180;
    end else if (deg >= DegW'(Rot270Lo) && deg <= DegW'(Rot270Hi)) begin
      orient_d = ORIENT_ROT270;
    end else begin
      orient_d = ORIENT_INVALID;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vec[ANGLE_ITERATIONS].vld) begin
      pend_flat_q <= flat;
      if (flat) begin
        pend_orient_q <= ORIENT_INVALID;
        pend_angle_q <= '1;
      end else begin
        pend_orient_q <= orient_d;
        pend_angle_q <= deg[9:0];
      end
    end
    if (move) begin
      out_orient_q <= pend_orient_q;
      out_angle_q <= pend_angle_q;
      out_flat_q <= pend_flat_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign orientation_o = out_orient_q;
  assign angle_deg_o = out_angle_q;
  assign is_flat_o = out_flat_q;

endmodule

/* rtl/core/goc_checker.sv */
module goc_checker
  import goc_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic        [2:0]  paddr,
  input logic        [31:0] pwdata,
  input logic        [31:0] prdata,
  input logic               pready,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic signed [15:0] gravity_x_i,
  input logic signed [15:0] gravity_y_i,
  input logic signed [15:0] gravity_z_i,
  input logic        [31:0] time_ms_i,
  input logic               is_gravity_type_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic        [2:0]  orientation_o,
  input logic signed [9:0]  angle_deg_o,
  input logic               is_flat_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(orientation_o)
      && $stable(angle_deg_o) && $stable(is_flat_o))
    else $error("output word changed while stalled");

  a_flat_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_flat_o |-> orientation_o == ORIENT_INVALID && angle_deg_o == -10'sd1)
    else $error("flat word malformed");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_flat_o |-> angle_deg_o >= 10'sd0 && angle_deg_o < 11'(FullTurnDeg))
    else $error("angle out of range");

  a_rot90_bin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && orientation_o == ORIENT_ROT90 |->
      angle_deg_o >= 10'(Rot90Lo) && angle_deg_o <= 10'(Rot90Hi))
    else $error("rot90 word outside its bin");

  a_rot0_bin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_flat_o && (angle_deg_o <= 10'(Rot0Hi) || angle_deg_o >= 10'(Rot0Lo))
      |-> orientation_o == ORIENT_ROT0)
    else $error("rot0 angle binned wrong");

endmodule

bind gravity_orientation_classifier_top goc_checker u_goc_checker (.*);

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
  import goc_pkg::*;

  localparam int unsigned AngleIters = 16;
  localparam int unsigned Latency = AngleIters + 3;
  localparam int unsigned Phases = 8;
  localparam int unsigned TakenPerPhase = 85;
  localparam int unsigned CycleLimit = 400_000;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [31:0] t;
    logic grav;
  } sample_t;

  typedef struct packed {
    orient_e orient;
    logic signed [9:0] angle;
    logic flat;
  } orient_word_t;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_SILENT,
    ROW_FIXED
  } row_kind_e;

  typedef struct packed {
    sample_t s;
    row_kind_e kind;
    orient_word_t fixed;
  } stim_row_t;

  localparam orient_word_t FlatWord = '{ORIENT_INVALID, -10'sd1, 1'b1};

  localparam stim_row_t DirectedRows [22] = '{
    '{'{16'sd1000, 16'sd0, 16'sd0, 32'd100, 1'b1}, ROW_SILENT, '0},
    '{'{16'sd1000, 16'sd0, 16'sd0, 32'd199, 1'b1}, ROW_SILENT, '0},
    '{'{16'sd0, 16'sd0, 16'sd0, 32'd200, 1'b1}, ROW_FIXED,
      '{ORIENT_ROT270, 10'sd270, 1'b0}},
    '{'{16'sd0, 16'sd1000, 16'sd0, 32'd300, 1'b1}, ROW_SILENT, '0},
    '{'{16'sd0, 16'sd1000, 16'sd0, 32'd400, 1'b0}, ROW_SILENT, '0},
    '{'{-16'sd1000, 16'sd0, 16'sd0, 32'd599, 1'b1}, ROW_SILENT, '0},
    '{'{16'sd0, 16'sd0, 16'sd100, 32'd600, 1'b1}, ROW_FIXED, FlatWord},
    '{'{16'sh8000, 16'sh8000, 16'sh8000, 32'd800, 1'b1}, ROW_PREDICT, '0},
    '{'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'd1000, 1'b1}, ROW_PREDICT, '0},
    '{'{16'sd16384, 16'sd0, 16'sd0, 32'd1200, 1'b1}, ROW_PREDICT, '0},
    '{'{-16'sd16384, 16'sd0, 16'sd0, 32'd1400, 1'b1}, ROW_PREDICT, '0},
    '{'{16'sd0, 16'sd16384, 16'sd0, 32'd1600, 1'b1}, ROW_PREDICT, '0},
    '{'{16'sd0, -16'sd16384, 16'sd0, 32'd1800, 1'b1}, ROW_PREDICT, '0},
    '{'{-16'sd1000, 16'sd1000, 16'sd0, 32'd2000, 1'b1}, ROW_PREDICT, '0},
    '{'{16'sh8000, -16'sd1, 16'sd0, 32'd2200, 1'b1}, ROW_PREDICT, '0},
    '{'{16'sd1, -16'sd1, 16'sd0, 32'd2400, 1'b1}, ROW_PREDICT, '0},
    '{'{-16'sd1, 16'sd0, 16'sh8000, 32'd2600, 1'b1}, ROW_FIXED, FlatWord},
    '{'{16'sh8000, 16'sh7FFF, 16'sd0, 32'hFFFF_FF00, 1'b1}, ROW_PREDICT, '0},
    '{'{16'sh7FFF, 16'sh8000, 16'sd0, 32'h0000_0010, 1'b1}, ROW_PREDICT, '0},
    '{'{16'sd100, 16'sd100, 16'sd0, 32'h0000_0020, 1'b1}, ROW_SILENT, '0},
    '{'{16'sd3000, -16'sd5000, 16'sd10, 32'h0000_0200, 1'b0}, ROW_SILENT, '0},
    '{'{16'sd300, -16'sd5000, -16'sd20000, 32'h0000_0300, 1'b1}, ROW_PREDICT, '0}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [15:0] gravity_x_i = '0;
  logic signed [15:0] gravity_y_i = '0;
  logic signed [15:0] gravity_z_i = '0;
  logic [31:0] time_ms_i = '0;
  logic is_gravity_type_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b1;
  logic [2:0] orientation_o;
  logic signed [9:0] angle_deg_o;
  logic is_flat_o;

  logic [15:0] cfg_min = MinIntervalReset;
  logic [3:0] cfg_ratio = TiltRatioReset;
  logic [31:0] last_time = '0;
  orient_word_t pending_words [$];
  orient_word_t head_word;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit calm = 1'b0;

  gravity_orientation_classifier_top #(
    .ANGLE_ITERATIONS(AngleIters)
  ) dut (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .in_valid_i,
    .in_ready_o,
    .gravity_x_i,
    .gravity_y_i,
    .gravity_z_i,
    .time_ms_i,
    .is_gravity_type_i,
    .out_valid_o,
    .out_ready_i,
    .orientation_o,
    .angle_deg_o,
    .is_flat_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int heading_deg(int x, int y);
    longint a;
    longint b;
    longint z;
    longint base;
    longint da;
    longint db;
    int steps;
    if (x == 0 && y == 0) begin
      return HalfTurnDeg;
    end
    a = -longint'(x);
    b = longint'(y);
    z = 0;
    base = 0;
    if (a < 0) begin
      base = (y >= 0) ? HalfTurnDeg : -HalfTurnDeg;
      a = -a;
      b = -b;
    end
    a = a * (longint'(1) << CordicScaleShift);
    b = b * (longint'(1) << CordicScaleShift);
    steps = (AngleIters > AngleTableLen) ? AngleTableLen : AngleIters;
    for (int i = 0; i < steps; i++) begin
      da = b >>> i;
      db = a >>> i;
      if (b >= 0) begin
        a = a + da;
        b = b - db;
        z = z + longint'(AtanQ16[i]);
      end else begin
        a = a - da;
        b = b + db;
        z = z - longint'(AtanQ16[i]);
      end
    end
    z = z + base * 65536;
    if (z >= 0) begin
      return int'((z + 32768) >>> 16);
    end
    return -int'(((-z) + 32768) >>> 16);
  endfunction

  function automatic orient_e degree_sector(int d);
    if (d >= 0 && (d <= Rot0Hi || d >= Rot0Lo)) return ORIENT_ROT0;
    if (d >= Rot90Lo && d <= Rot90Hi) return ORIENT_ROT90;
    if (d >= Rot180Lo && d <= Rot180Hi) return ORIENT_ROT180;
    if (d >= Rot270Lo && d <= Rot270Hi) return ORIENT_ROT270;
    return ORIENT_INVALID;
  endfunction

  function automatic void classify_sample(input sample_t s, output bit taken,
                                          output bit has, output orient_word_t w);
    logic [31:0] dt;
    longint horiz;
    longint vert;
    int d;
    taken = 1'b0;
    has = 1'b0;
    w = '0;
    dt = s.t - last_time;
    if (dt < {16'd0, cfg_min}) return;
    taken = 1'b1;
    last_time = s.t;
    if (!s.grav) return;
    has = 1'b1;
    horiz = longint'(s.x) * longint'(s.x) + longint'(s.y) * longint'(s.y);
    vert = longint'(s.z) * longint'(s.z);
    if (horiz * longint'(cfg_ratio) < vert) begin
      w = FlatWord;
      return;
    end
    d = QuarterTurnDeg - heading_deg(int'(s.x), int'(s.y));
    if (d < 0) d = d + FullTurnDeg;
    if (d >= FullTurnDeg) d = d - FullTurnDeg;
    w.orient = degree_sector(d);
    w.angle = d[9:0];
    w.flat = 1'b0;
  endfunction

  function automatic logic signed [15:0] rand_axis();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 200)) - 16'sd100;
      2: begin
        case ($urandom_range(0, 4))
          0: return 16'sh8000;
          1: return 16'sh7FFF;
          2: return 16'sd0;
          3: return -16'sd1;
          default: return 16'sd1;
        endcase
      end
      default: return 16'($urandom_range(0, 16000)) - 16'sd8000;
    endcase
  endfunction

  task automatic apb_write(input reg_e idx, input logic [31:0] value);
    logic [31:0] junk;
    junk = $urandom;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    if (idx == REG_MIN_INTERVAL) begin
      pwdata <= {junk[31:16], value[15:0]};
    end else begin
      pwdata <= {junk[31:4], value[3:0]};
    end
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_MIN_INTERVAL) begin
      cfg_min = value[15:0];
    end else begin
      cfg_ratio = value[3:0];
    end
  endtask

  task automatic send_sample(input sample_t s, input row_kind_e kind,
                             input orient_word_t fixed, output bit taken);
    bit has;
    orient_word_t w;
    in_valid_i <= 1'b1;
    gravity_x_i <= s.x;
    gravity_y_i <= s.y;
    gravity_z_i <= s.z;
    time_ms_i <= s.t;
    is_gravity_type_i <= s.grav;
    do @(posedge clk_i); while (!in_ready_o);
    classify_sample(s, taken, has, w);
    case (kind)
      ROW_PREDICT: if (has) pending_words.push_back(w);
      ROW_FIXED: pending_words.push_back(fixed);
      default: ;
    endcase
  endtask

  task automatic idle_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (4 * Latency) @(posedge clk_i);
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 9) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_words.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected word: orientation %0d angle %0d flat %0b",
                 $time, orientation_o, angle_deg_o, is_flat_o);
      end else begin
        head_word = pending_words.pop_front();
        if (orientation_o !== head_word.orient) begin
          err_cnt++;
          $display("%0t: orientation expected %0d actual %0d",
                   $time, head_word.orient, orientation_o);
        end
        if (angle_deg_o !== head_word.angle) begin
          err_cnt++;
          $display("%0t: angle_deg expected %0d actual %0d",
                   $time, head_word.angle, angle_deg_o);
        end
        if (is_flat_o !== head_word.flat) begin
          err_cnt++;
          $display("%0t: is_flat expected %0b actual %0b",
                   $time, head_word.flat, is_flat_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    sample_t s;
    bit taken;
    int unsigned n;
    logic [31:0] cur_t;
    logic [31:0] step;
    logic [15:0] new_min;
    logic [3:0] new_ratio;
    int unsigned r;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < $size(DirectedRows); i++) begin
      send_sample(DirectedRows[i].s, DirectedRows[i].kind, DirectedRows[i].fixed, taken);
      idle_gap();
    end
    settle();

    cur_t = last_time;
    for (int ph = 0; ph < Phases; ph++) begin
      case (ph)
        0: begin
          new_min = 16'd0;
          new_ratio = 4'd0;
        end
        1: begin
          new_min = 16'hFFFF;
          new_ratio = 4'hF;
        end
        2: begin
          new_min = 16'd1;
          new_ratio = 4'd1;
        end
        default: begin
          new_min = 16'($urandom_range(0, 400));
          new_ratio = 4'($urandom_range(0, 15));
        end
      endcase
      apb_write(REG_MIN_INTERVAL, 32'(new_min));
      apb_write(REG_TILT_RATIO, 32'(new_ratio));
      calm = (ph == Phases - 1);
      n = 0;
      while (n < TakenPerPhase) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          step = 32'(cfg_min) + $urandom_range(0, cfg_min / 2 + 20);
        end else if (r < 90) begin
          step = $urandom_range(0, cfg_min);
        end else begin
          step = $urandom;
        end
        cur_t = cur_t + step;
        s.x = rand_axis();
        s.y = rand_axis();
        s.z = rand_axis();
        s.t = cur_t;
        s.grav = ($urandom_range(0, 9) != 0);
        send_sample(s, ROW_PREDICT, '0, taken);
        if (taken) n++;
        idle_gap();
      end
      settle();
    end

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* gravity_orientation_classifier_top.f */
rtl/core/goc_pkg.sv
rtl/core/goc_cordic_cell.sv
rtl/core/goc_tilt.sv
rtl/core/gravity_orientation_classifier_top.sv
rtl/core/goc_checker.sv
tb/tb.sv
